@@ rtl/core/ndiff_pkg.sv @@
// ndiff_pkg: shared constants and types of the neighbor difference edge detector
// used by ndiff_edge_unit and neighbor_diff_edge_detector_unit
// no dependencies

package ndiff_pkg;

	// pixel and position widths
	localparam int PIX_W        = 8;
	localparam int ROW_W        = 16;
	localparam int COL_W        = 10;

	// image size limits
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 65536;

	// line store: three row slots of MAX_WIDTH pixels
	localparam int NUM_SLOTS    = 3;
	localparam int SLOT_W       = 2;
	localparam int ADDR_W       = SLOT_W + COL_W;
	localparam int STORE_DEPTH  = NUM_SLOTS * MAX_WIDTH;

	// configuration registers
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 17;
	localparam int CFG_DATA_W   = 17;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, index 0 is the oldest row
	typedef pix_t [2:0] col_t;

	// 3x3 window, [row][col], row 0 on top, col 0 on the left
	typedef pix_t [2:0][2:0] win_t;

	// which neighbors of the window center lie inside the image
	typedef struct packed {
		logic up_ok;
		logic down_ok;
		logic left_ok;
		logic right_ok;
	} nbr_ok_t;

endpackage

@@ rtl/core/neighbor_diff_edge_detector_unit.sv @@
// neighbor_diff_edge_detector_unit: 3x3 max absolute neighbor difference over a raster stream
// holds the line store memory, position counters, window and result sequencer
// depends on ndiff_pkg and ndiff_edge_unit

// Pixels enter in raster order, one per input transfer; each pixel is written into a
// three-row line store (one memory, one write and two reads per cycle, registered read
// data) while the two pixels above it are read back and shifted into a 3x3 window. A
// pixel's edge value is issued once its whole neighborhood has arrived, tagged with its
// row and column. A new pixel is taken every cycle as long as each pixel causes at most
// one result and the output does not stall: the single shared edge unit issues one result
// per cycle, so a pixel that releases more, as at a row end or in the final row, holds the
// input until its results are issued. The first result of a pixel passes stage 1 and
// stage 2 into the output register. Writing either configuration register restarts the
// image at row 0, column 0; counters also wrap after the last pixel, so images follow
// each other without a gap. The line store needs no clearing after reset.

module neighbor_diff_edge_detector_unit import ndiff_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// pixel input
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIX_W-1:0]        pixel_value,
	// edge output
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ROW_W-1:0]        edge_row,
	output logic [COL_W-1:0]        edge_col,
	output logic [PIX_W-1:0]        edge_value,
	output logic                    last_of_run
);

	// configuration, held as last column and last row index
	logic [COL_W-1:0]        wlast_q;
	logic [ROW_W-1:0]        hlast_q;
	logic [WIDTH_REG_W-1:0]  cfg_w;
	logic [HEIGHT_REG_W-1:0] cfg_h;
	logic [WIDTH_REG_W-1:0]  cfg_w_m1;
	logic [HEIGHT_REG_W-1:0] cfg_h_m1;
	logic [COL_W-1:0]        wlast_new;
	logic [ROW_W-1:0]        hlast_new;

	// position counters
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_prev;
	logic [SLOT_W-1:0] slot_prev2;
	logic [SLOT_W-1:0] slot_next;
	logic              at_last_col;
	logic              at_last_row;
	logic [3:0]        res_mask;

	// line store
	pix_t              store_mem [STORE_DEPTH];

	// stage 1: read data and position
	logic              valid_s1;
	pix_t              up_rd_s1;
	pix_t              mid_rd_s1;
	pix_t              pix_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic [3:0]        mask_s1;

	// earlier window columns
	col_t              cola_q;
	col_t              colb_q;
	col_t              new_col;

	// stage 2: window and pending results
	logic              valid_s2;
	win_t              win_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;
	logic [3:0]        mask_s2;

	// result selection
	logic [3:0]        mask_next;
	logic              ctr_row2;
	logic              ctr_col2;
	win_t              ctr_win;
	nbr_ok_t           nbr_ok;
	pix_t              max_diff;

	// output register
	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	pix_t              out_val_q;
	logic              out_last_q;

	// handshake
	logic              in_xfer;
	logic              out_xfer;
	logic              out_load;
	logic              s2_ready;
	logic              s1_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_load = valid_s2 && (!out_valid_q || !out_stall);
	assign s2_ready = !valid_s2 || (out_load && (mask_next == 4'b0000));
	assign s1_xfer  = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;

	// clamp written size to the supported range
	always_comb begin
		cfg_w    = cfg_data[WIDTH_REG_W-1:0];
		cfg_h    = cfg_data[HEIGHT_REG_W-1:0];
		cfg_w_m1 = cfg_w - WIDTH_REG_W'(1);
		cfg_h_m1 = cfg_h - HEIGHT_REG_W'(1);
		if (cfg_w == '0) begin
			wlast_new = '0;
		end else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH)) begin
			wlast_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			wlast_new = cfg_w_m1[COL_W-1:0];
		end
		if (cfg_h == '0) begin
			hlast_new = '0;
		end else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			hlast_new = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hlast_new = cfg_h_m1[ROW_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= COL_W'(MAX_WIDTH - 1);
			hlast_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IDX_WIDTH:  wlast_q <= wlast_new;
				CFG_IDX_HEIGHT: hlast_q <= hlast_new;
				default: ;
			endcase
		end
	end

	// slot neighbors of the current row
	always_comb begin
		case (slot_q)
			2'd0:    begin slot_prev = 2'd2; slot_prev2 = 2'd1; slot_next = 2'd1; end
			2'd1:    begin slot_prev = 2'd0; slot_prev2 = 2'd2; slot_next = 2'd2; end
			default: begin slot_prev = 2'd1; slot_prev2 = 2'd0; slot_next = 2'd0; end
		endcase
	end

	// results this pixel releases, in issue order
	always_comb begin
		at_last_col = (col_q >= wlast_q);
		at_last_row = (row_q >= hlast_q);
		res_mask[0] = (row_q != '0) && (col_q != '0);
		res_mask[1] = (row_q != '0) && at_last_col;
		res_mask[2] = at_last_row && (col_q != '0);
		res_mask[3] = at_last_row && at_last_col;
	end

	// position counters, restarted by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (cfg_write) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (in_xfer) begin
			if (at_last_col) begin
				col_q <= '0;
				if (at_last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					slot_q <= slot_next;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line store: write the new pixel, read the two rows above it
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			store_mem[{slot_q, col_q}] <= pixel_value;
			up_rd_s1  <= store_mem[{slot_prev2, col_q}];
			mid_rd_s1 <= store_mem[{slot_prev, col_q}];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1  <= pixel_value;
			row_s1  <= row_q;
			col_s1  <= col_q;
			mask_s1 <= res_mask;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	// newest window column
	assign new_col = {pix_s1, mid_rd_s1, up_rd_s1};

	// window shift and stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_xfer) begin
			colb_q <= cola_q;
			cola_q <= new_col;
			for (int rr = 0; rr < 3; rr++) begin
				win_s2[rr][0] <= colb_q[rr];
				win_s2[rr][1] <= cola_q[rr];
				win_s2[rr][2] <= new_col[rr];
			end
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	// stage 2 pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else if (s1_xfer) begin
			valid_s2 <= (mask_s1 != 4'b0000);
			mask_s2  <= mask_s1;
		end else if (out_load) begin
			valid_s2 <= (mask_next != 4'b0000);
			mask_s2  <= mask_next;
		end
	end

	// pick the first pending result
	always_comb begin
		ctr_row2  = 1'b0;
		ctr_col2  = 1'b0;
		mask_next = mask_s2;
		if (mask_s2[0]) begin
			mask_next[0] = 1'b0;
		end else if (mask_s2[1]) begin
			ctr_col2     = 1'b1;
			mask_next[1] = 1'b0;
		end else if (mask_s2[2]) begin
			ctr_row2     = 1'b1;
			mask_next[2] = 1'b0;
		end else begin
			ctr_row2     = 1'b1;
			ctr_col2     = 1'b1;
			mask_next[3] = 1'b0;
		end
	end

	// recenter the window on the chosen pixel
	always_comb begin
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if ((ctr_row2 && rr == 2) || (ctr_col2 && cc == 2)) begin
					ctr_win[rr][cc] = '0;
				end else if (ctr_row2 && ctr_col2) begin
					ctr_win[rr][cc] = win_s2[rr+1][cc+1];
				end else if (ctr_row2) begin
					ctr_win[rr][cc] = win_s2[rr+1][cc];
				end else if (ctr_col2) begin
					ctr_win[rr][cc] = win_s2[rr][cc+1];
				end else begin
					ctr_win[rr][cc] = win_s2[rr][cc];
				end
			end
		end
		nbr_ok.up_ok    = ctr_row2 ? (row_s2 >= ROW_W'(1)) : (row_s2 >= ROW_W'(2));
		nbr_ok.down_ok  = !ctr_row2;
		nbr_ok.left_ok  = ctr_col2 ? (col_s2 >= COL_W'(1)) : (col_s2 >= COL_W'(2));
		nbr_ok.right_ok = !ctr_col2;
	end

	ndiff_edge_unit u_edge (
		.win      (ctr_win),
		.ok       (nbr_ok),
		.max_diff (max_diff)
	);

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= ctr_row2 ? row_s2 : row_s2 - ROW_W'(1);
			out_col_q  <= ctr_col2 ? col_s2 : col_s2 - COL_W'(1);
			out_val_q  <= max_diff;
			out_last_q <= (mask_next == 4'b0000);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign edge_row    = out_row_q;
	assign edge_col    = out_col_q;
	assign edge_value  = out_val_q;
	assign last_of_run = out_last_q;

	// a busy stage 2 always has a result left to issue
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (mask_s2 != 4'b0000))
		else $error("stage 2 busy with no pending result");

	// column counter stays inside the configured row
	assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wlast_q)
		else $error("column counter beyond last column");

	// row slot is one of the three line store slots
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != 2'd3)
		else $error("invalid row slot");

	// a result that is not the last of its pixel is followed at once by the next
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) |=> out_valid)
		else $error("gap inside a run of results");

endmodule

@@ rtl/core/ndiff_edge_unit.sv @@
// ndiff_edge_unit: largest absolute difference between a window center and its
// in-image neighbors, zero when none is in the image
// depends on ndiff_pkg

module ndiff_edge_unit import ndiff_pkg::*; (
	input  win_t    win,
	input  nbr_ok_t ok,
	output pix_t    max_diff
);

	pix_t diff [8];
	pix_t lvl1 [4];
	pix_t lvl2 [2];

	// masked absolute differences of the eight neighbors
	always_comb begin
		int   n;
		pix_t ctr;
		pix_t nb;
		logic in_img;
		n   = 0;
		ctr = win[1][1];
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (!(rr == 1 && cc == 1)) begin
					nb     = win[rr][cc];
					in_img = (rr != 0 || ok.up_ok) && (rr != 2 || ok.down_ok) &&
						(cc != 0 || ok.left_ok) && (cc != 2 || ok.right_ok);
					if (!in_img) begin
						diff[n] = '0;
					end else if (nb > ctr) begin
						diff[n] = nb - ctr;
					end else begin
						diff[n] = ctr - nb;
					end
					n = n + 1;
				end
			end
		end
	end

	// max tree over the eight differences
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lvl1[i] = (diff[2*i] > diff[2*i+1]) ? diff[2*i] : diff[2*i+1];
		end
		for (int i = 0; i < 2; i++) begin
			lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		end
		max_diff = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
	end

endmodule

@@ test/neighbor_diff_edge_detector_unit_tb.sv @@
// neighbor_diff_edge_detector_unit_tb: self-checking testbench of the 3x3 neighbor difference edge detector
// streams directed and random images and compares every edge result against a scoreboard prediction
// depends on ndiff_pkg and neighbor_diff_edge_detector_unit

module neighbor_diff_edge_detector_unit_tb;
	import ndiff_pkg::*;

	// random phases feed at least RANDOM_ITEMS pixels with random gaps and stalls, each phase ending in a drain
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int RANDOM_ITEMS  = 450;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] value;
		logic             last;
	} edge_result_t;

	// predicts edge results per pixel transfer and checks them in order
	class edge_scoreboard;
		pix_t                    pixels [NUM_SLOTS][MAX_WIDTH];
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		int unsigned             row_pos;
		int unsigned             col_pos;
		int unsigned             cur_slot;
		edge_result_t            pending [$];
		int unsigned             errors;

		function new();
			width_reg  = WIDTH_REG_W'(MAX_WIDTH);
			height_reg = HEIGHT_REG_W'(1);
			row_pos    = 0;
			col_pos    = 0;
			cur_slot   = 0;
			errors     = 0;
		endfunction

		// zero acts as one, oversize acts as the limit
		static function int unsigned clamp_size(int unsigned v, int unsigned hi);
			if (v == 0) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		// any register write restarts the image, the line store is kept
		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_IDX_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
			else if (idx == CFG_IDX_HEIGHT) height_reg = data[HEIGHT_REG_W-1:0];
			row_pos  = 0;
			col_pos  = 0;
			cur_slot = 0;
		endfunction

		// largest absolute difference of the pixel at slot mid, column c, to its in-image neighbors
		function pix_t neighbor_max(int unsigned mid, bit up_ok, bit down_ok, int unsigned c,
				int unsigned w);
			int unsigned row_slot [3];
			bit          row_ok [3];
			int          centre;
			int          best;
			int          diff;
			int          nc;
			row_slot[0] = (mid + 2) % NUM_SLOTS;
			row_slot[1] = mid % NUM_SLOTS;
			row_slot[2] = (mid + 1) % NUM_SLOTS;
			row_ok[0]   = up_ok;
			row_ok[1]   = 1'b1;
			row_ok[2]   = down_ok;
			centre      = int'(pixels[mid % NUM_SLOTS][c]);
			best        = 0;
			for (int dr = 0; dr < 3; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					if (!row_ok[dr] || (dr == 1 && dc == 0)) continue;
					if (dc < 0 && c == 0) continue;
					if (dc > 0 && c + 1 >= w) continue;
					nc   = int'(c) + dc;
					diff = int'(pixels[row_slot[dr]][nc]) - centre;
					if (diff < 0) diff = -diff;
					if (diff > best) best = diff;
				end
			end
			return pix_t'(best);
		endfunction

		function void add_result(int unsigned r, int unsigned c, pix_t v);
			edge_result_t res;
			res.row   = ROW_W'(r);
			res.col   = COL_W'(c);
			res.value = v;
			res.last  = 1'b0;
			pending.push_back(res);
		endfunction

		// store the pixel and queue every result it releases
		function void note_pixel(pix_t p);
			int unsigned w, h, r, c, s, prev;
			bit          last_col, last_row;
			int          first;
			w        = clamp_size(width_reg, MAX_WIDTH);
			h        = clamp_size(height_reg, MAX_HEIGHT);
			r        = row_pos;
			c        = col_pos;
			s        = cur_slot % NUM_SLOTS;
			prev     = (s + 2) % NUM_SLOTS;
			last_col = (c + 1 >= w);
			last_row = (r + 1 >= h);
			first    = pending.size();
			if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
			pixels[s][c] = p;

			// row above is complete up to here
			if (r >= 1) begin
				if (c >= 1) add_result(r - 1, c - 1, neighbor_max(prev, r >= 2, 1'b1, c - 1, w));
				if (last_col) add_result(r - 1, c, neighbor_max(prev, r >= 2, 1'b1, c, w));
			end
			// final row has no row below, so it drains right away
			if (last_row) begin
				if (c >= 1) add_result(r, c - 1, neighbor_max(s, r >= 1, 1'b0, c - 1, w));
				if (last_col) add_result(r, c, neighbor_max(s, r >= 1, 1'b0, c, w));
			end
			if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;

			// advance position, wrap to a clean image after the last pixel
			if (last_col) begin
				col_pos = 0;
				if (last_row) begin
					row_pos  = 0;
					cur_slot = 0;
				end else begin
					row_pos  = r + 1;
					cur_slot = (s + 1) % NUM_SLOTS;
				end
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_result(edge_result_t got);
			edge_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$error("edge result row %0d col %0d arrived with nothing expected", got.row, got.col);
				return;
			end
			want = pending.pop_front();
			if (got.row !== want.row) begin
				errors++;
				$error("edge_row expected %0d actual %0d", want.row, got.row);
			end
			if (got.col !== want.col) begin
				errors++;
				$error("edge_col expected %0d actual %0d", want.col, got.col);
			end
			if (got.value !== want.value) begin
				errors++;
				$error("edge_value expected %0d actual %0d", want.value, got.value);
			end
			if (got.last !== want.last) begin
				errors++;
				$error("last_of_run expected %0d actual %0d", want.last, got.last);
			end
		endfunction
	endclass

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = CFG_IDX_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	pix_t                  pixel_value = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [ROW_W-1:0]      edge_row;
	logic [COL_W-1:0]      edge_col;
	logic [PIX_W-1:0]      edge_value;
	logic                  last_of_run;

	edge_scoreboard edge_sb;
	bit             sender_idle    = 1'b1;
	bit             receiver_stall = 1'b1;
	int             burst_left     = 0;
	int             stall_left     = 0;
	int             fed_items      = 0;
	int unsigned    cycle_count    = 0;

	neighbor_diff_edge_detector_unit i_dut (.*);

	initial forever #5 clk = ~clk;

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// receiver stalls in random runs, or never while disabled
	always @(negedge clk) begin
		if (!receiver_stall) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// sample both transfers at the rising edge
	always @(posedge clk) begin : transfer_monitor
		edge_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) edge_sb.note_pixel(pixel_value);
			if (out_valid && !out_stall) begin
				got.row   = edge_row;
				got.col   = edge_col;
				got.value = edge_value;
				got.last  = last_of_run;
				edge_sb.check_result(got);
			end
		end
	end

	function automatic pix_t random_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return pix_t'($urandom);
		endcase
	endfunction

	// width word with random bits above the register
	function automatic logic [CFG_DATA_W-1:0] width_word(int unsigned w);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
		return word;
	endfunction

	// one pixel transfer, bursts separated by random gaps
	task automatic send_pixel(pix_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid    <= 1'b1;
		pixel_value <= p;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic feed_pixels(int count);
		repeat (count) send_pixel(random_pixel());
		fed_items += count;
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		edge_sb.apply_register(idx, data);
	endtask

	// both registers, in random order
	task automatic set_image(int unsigned w, int unsigned h);
		if ($urandom_range(0, 1) == 0) begin
			write_cfg(CFG_IDX_WIDTH, width_word(w));
			write_cfg(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
		end else begin
			write_cfg(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
			write_cfg(CFG_IDX_WIDTH, width_word(w));
		end
	endtask

	// stop sending, drain expected results, let the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (edge_sb.pending.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned w, h, image_pixels;
		int          count;
		edge_sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: 1024 wide single row, so every pixel but the first releases a result
		send_pixel('0);
		send_pixel('1);
		send_pixel(8'd128);
		send_pixel(8'd1);
		wait_idle();

		// 3x3 checkerboard of extremes, covers corners, edges and center
		set_image(3, 3);
		for (int i = 0; i < 9; i++) send_pixel((i % 2) ? '1 : '0);
		wait_idle();

		// zero sizes act as one: two back to back single-pixel images
		set_image(0, 0);
		send_pixel('1);
		send_pixel('0);
		wait_idle();

		// single column, vertical neighbors only
		set_image(1, 3);
		send_pixel('1);
		send_pixel('0);
		send_pixel(8'd77);
		wait_idle();

		// 2x2 with a restart by a height write part way through
		set_image(2, 2);
		send_pixel(8'd10);
		send_pixel(8'd200);
		send_pixel(8'd90);
		wait_idle();
		write_cfg(CFG_IDX_HEIGHT, CFG_DATA_W'(2));
		for (int i = 0; i < 4; i++) send_pixel(random_pixel());
		wait_idle();

		// random phases: mostly small complete images, some partial ones cut by a restart
		while (fed_items < RANDOM_ITEMS) begin
			sender_idle    = ($urandom_range(0, 4) != 0);
			receiver_stall = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 11))
				0:       w = 0;
				1:       w = $urandom_range(MAX_WIDTH + 1, 2 ** WIDTH_REG_W - 1);
				2:       w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 11))
				0:       h = 0;
				1:       h = $urandom_range(MAX_HEIGHT, 2 ** HEIGHT_REG_W - 1);
				default: h = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 5))
				0:       write_cfg(CFG_IDX_WIDTH, width_word(w));
				1:       write_cfg(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
				default: set_image(w, h);
			endcase
			image_pixels = edge_scoreboard::clamp_size(edge_sb.width_reg, MAX_WIDTH) *
				edge_scoreboard::clamp_size(edge_sb.height_reg, MAX_HEIGHT);
			if (image_pixels > 80) begin
				count = $urandom_range(1, 80);
			end else begin
				count = image_pixels * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0) count += $urandom_range(1, image_pixels);
			end
			feed_pixels(count);
			wait_idle();
		end

		if (edge_sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ndiff_pkg.sv
rtl/core/ndiff_edge_unit.sv
rtl/core/neighbor_diff_edge_detector_unit.sv
test/neighbor_diff_edge_detector_unit_tb.sv
